// ===== rtl/sta_pkg.sv =====
// package for the sorted trigger/action table
// types, codes and reset values shared by sta_ctl, sta_dp and the top level
package sta_pkg;

  localparam int TABLE_DEPTH_DEF = 8;

  localparam int CODE_W   = 8;
  localparam int ENTRY_W  = 2 * CODE_W;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W  = 4;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_KNOWN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_SUPP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_KNOWN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_SUPP     = 3'd4;

  localparam logic [CODE_W-1:0] TRIG_LOW_RST   = 8'd0;
  localparam logic [CODE_W-1:0] TRIG_KNOWN_RST = 8'd5;
  localparam logic [CODE_W-1:0] TRIG_SUPP_RST  = 8'd3;
  localparam logic [CODE_W-1:0] ACT_KNOWN_RST  = 8'd5;
  localparam logic [CODE_W-1:0] ACT_SUPP_RST   = 8'd3;

  localparam logic [CODE_W-1:0] ACT_NONE = 8'd0;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_FULL        = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MISS,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_RD,
    S_INS_WR,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    WR_ITEM_IDX,
    WR_DATA_IDXM1,
    WR_DATA_SH
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    rd;
    logic    rd_from_sh;
    logic    wr;
    wr_sel_t wr_sel;
    logic    idx_inc;
    logic    sh_load;
    logic    sh_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    take_act;
    logic    set_changed;
    logic    set_full;
    logic    load_out;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_set;
    logic trig_known;
    logic chk_ok;
    logic act_zero;
    logic scan_end;
    logic hit;
    logic past;
    logic same_act;
    logic full;
    logic sh_at_idx;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/sta_ctl.sv =====
// controller state machine of the sorted trigger/action table
// depends on sta_pkg; drives sta_dp through ctl_cmd_t, reads dp_sts_t
module sta_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sta_pkg::dp_sts_t  sts,
  output sta_pkg::ctl_cmd_t cmd
);

  sta_pkg::state_t state_r;
  sta_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sta_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == sta_pkg::S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      sta_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sta_pkg::S_SCAN_RD;
        end
      end
      sta_pkg::S_SCAN_RD: begin
        // rejected set, or get of an unknown trigger: no search
        if (sts.is_set ? !sts.chk_ok : !sts.trig_known) begin
          state_nxt = sta_pkg::S_FINISH;
        end else if (sts.scan_end) begin
          state_nxt = sta_pkg::S_MISS;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = sta_pkg::S_SCAN_CMP;
        end
      end
      sta_pkg::S_SCAN_CMP: begin
        if (sts.hit) begin
          if (!sts.is_set) begin
            cmd.take_act = 1'b1;
            state_nxt    = sta_pkg::S_FINISH;
          end else if (sts.act_zero) begin
            cmd.idx_inc = 1'b1;
            state_nxt   = sta_pkg::S_DEL_RD;
          end else if (sts.same_act) begin
            state_nxt = sta_pkg::S_FINISH;
          end else begin
            cmd.wr          = 1'b1;
            cmd.wr_sel      = sta_pkg::WR_ITEM_IDX;
            cmd.set_changed = 1'b1;
            state_nxt       = sta_pkg::S_FINISH;
          end
        end else if (sts.past) begin
          state_nxt = sta_pkg::S_MISS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = sta_pkg::S_SCAN_RD;
        end
      end
      sta_pkg::S_MISS: begin
        // idx now holds the sorted insert position
        if (sts.is_set && !sts.act_zero) begin
          if (sts.full) begin
            cmd.set_full = 1'b1;
            state_nxt    = sta_pkg::S_FINISH;
          end else begin
            cmd.sh_load = 1'b1;
            state_nxt   = sta_pkg::S_INS_RD;
          end
        end else begin
          state_nxt = sta_pkg::S_FINISH;
        end
      end
      sta_pkg::S_DEL_RD: begin
        if (sts.scan_end) begin
          cmd.cnt_dec     = 1'b1;
          cmd.set_changed = 1'b1;
          state_nxt       = sta_pkg::S_FINISH;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = sta_pkg::S_DEL_WR;
        end
      end
      sta_pkg::S_DEL_WR: begin
        cmd.wr      = 1'b1;
        cmd.wr_sel  = sta_pkg::WR_DATA_IDXM1;
        cmd.idx_inc = 1'b1;
        state_nxt   = sta_pkg::S_DEL_RD;
      end
      sta_pkg::S_INS_RD: begin
        if (sts.sh_at_idx) begin
          cmd.wr          = 1'b1;
          cmd.wr_sel      = sta_pkg::WR_ITEM_IDX;
          cmd.cnt_inc     = 1'b1;
          cmd.set_changed = 1'b1;
          state_nxt       = sta_pkg::S_FINISH;
        end else begin
          cmd.rd         = 1'b1;
          cmd.rd_from_sh = 1'b1;
          state_nxt      = sta_pkg::S_INS_WR;
        end
      end
      sta_pkg::S_INS_WR: begin
        cmd.wr     = 1'b1;
        cmd.wr_sel = sta_pkg::WR_DATA_SH;
        cmd.sh_dec = 1'b1;
        state_nxt  = sta_pkg::S_INS_RD;
      end
      sta_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = sta_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sta_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sta_dp.sv =====
// datapath of the sorted trigger/action table: config registers, item
// registers, entry memory, cursors and result/output registers; uses sta_pkg
module sta_dp #(
  parameter int DEPTH = sta_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_operation,
  input  logic [sta_pkg::CODE_W-1:0]       in_trigger,
  input  logic [sta_pkg::CODE_W-1:0]       in_action,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic [sta_pkg::CODE_W-1:0]       out_action_out,
  output logic                             out_changed,
  output logic [sta_pkg::COUNT_W-1:0]      out_entry_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sta_pkg::CODE_W-1:0]       cfg_data,
  input  sta_pkg::ctl_cmd_t                cmd,
  output sta_pkg::dp_sts_t                 sts
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int W  = sta_pkg::CODE_W;

  // config registers
  logic [W-1:0] trig_low_r, trig_known_r, trig_supp_r, act_known_r, act_supp_r;

  // item registers
  logic         op_r;
  logic [W-1:0] trig_r;
  logic [W-1:0] act_r;
  logic         known_r;
  logic         chk_ok_r;

  // cursors and count
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] sh_r;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] sh_m1;

  // entry memory, {trigger, action}
  logic [sta_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [sta_pkg::ENTRY_W-1:0] rdata_r;
  logic [sta_pkg::ENTRY_W-1:0] wdata;
  logic [AW-1:0]               raddr;
  logic [AW-1:0]               waddr;

  // result registers
  sta_pkg::status_t res_status_r;
  logic [W-1:0]     res_act_r;
  logic             res_changed_r;

  // output registers
  logic                        out_valid_r;
  sta_pkg::status_t            out_status_r;
  logic [W-1:0]                out_act_r;
  logic                        out_changed_r;
  logic [sta_pkg::COUNT_W-1:0] out_count_r;
  logic [CW+sta_pkg::COUNT_W-1:0] cnt_ext;

  logic in_known, in_supp, in_act_known, in_act_supp;
  sta_pkg::status_t in_chk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_low_r   <= sta_pkg::TRIG_LOW_RST;
      trig_known_r <= sta_pkg::TRIG_KNOWN_RST;
      trig_supp_r  <= sta_pkg::TRIG_SUPP_RST;
      act_known_r  <= sta_pkg::ACT_KNOWN_RST;
      act_supp_r   <= sta_pkg::ACT_SUPP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sta_pkg::CFG_TRIG_LOW:   trig_low_r   <= cfg_data;
        sta_pkg::CFG_TRIG_KNOWN: trig_known_r <= cfg_data;
        sta_pkg::CFG_TRIG_SUPP:  trig_supp_r  <= cfg_data;
        sta_pkg::CFG_ACT_KNOWN:  act_known_r  <= cfg_data;
        sta_pkg::CFG_ACT_SUPP:   act_supp_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // argument checks on the incoming item
  assign in_known     = (in_trigger >= trig_low_r) && (in_trigger <= trig_known_r);
  assign in_supp      = (in_trigger >= trig_low_r) && (in_trigger <= trig_supp_r);
  assign in_act_known = (in_action <= act_known_r);
  assign in_act_supp  = (in_action <= act_supp_r);

  always_comb begin
    if (!in_known || !in_act_known) begin
      in_chk = sta_pkg::ST_INVALID;
    end else if (!in_supp || !in_act_supp) begin
      in_chk = sta_pkg::ST_UNSUPPORTED;
    end else begin
      in_chk = sta_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_operation;
      trig_r   <= in_trigger;
      act_r    <= in_action;
      known_r  <= in_known;
      chk_ok_r <= (in_chk == sta_pkg::ST_OK);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status_r  <= (in_operation == sta_pkg::OP_SET) ? in_chk : sta_pkg::ST_OK;
      res_act_r     <= sta_pkg::ACT_NONE;
      res_changed_r <= 1'b0;
    end else begin
      if (cmd.set_full) begin
        res_status_r <= sta_pkg::ST_FULL;
      end
      if (cmd.take_act) begin
        res_act_r <= rdata_r[W-1:0];
      end
      if (cmd.set_changed) begin
        res_changed_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      sh_r  <= '0;
    end else begin
      if (cmd.accept) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.sh_load) begin
        sh_r <= cnt_r;
      end else if (cmd.sh_dec) begin
        sh_r <= sh_m1;
      end
    end
  end

  assign idx_m1 = idx_r - CW'(1);
  assign sh_m1  = sh_r - CW'(1);
  assign raddr  = cmd.rd_from_sh ? sh_m1[AW-1:0] : idx_r[AW-1:0];

  always_comb begin
    case (cmd.wr_sel)
      sta_pkg::WR_DATA_IDXM1: begin
        waddr = idx_m1[AW-1:0];
        wdata = rdata_r;
      end
      sta_pkg::WR_DATA_SH: begin
        waddr = sh_r[AW-1:0];
        wdata = rdata_r;
      end
      default: begin
        waddr = idx_r[AW-1:0];
        wdata = {trig_r, act_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[raddr];
    end
  end

  // output register, loaded while free or being taken
  assign cnt_ext = {{sta_pkg::COUNT_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= res_status_r;
      out_act_r     <= res_act_r;
      out_changed_r <= res_changed_r;
      out_count_r   <= cnt_ext[sta_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_action_out  = out_act_r;
  assign out_changed     = out_changed_r;
  assign out_entry_count = out_count_r;

  assign sts.is_set     = (op_r == sta_pkg::OP_SET);
  assign sts.trig_known = known_r;
  assign sts.chk_ok     = chk_ok_r;
  assign sts.act_zero   = (act_r == sta_pkg::ACT_NONE);
  assign sts.scan_end   = (idx_r == cnt_r);
  assign sts.hit        = (rdata_r[sta_pkg::ENTRY_W-1:W] == trig_r);
  assign sts.past       = (rdata_r[sta_pkg::ENTRY_W-1:W] > trig_r);
  assign sts.same_act   = (rdata_r[W-1:0] == act_r);
  assign sts.full       = (cnt_r == CW'(DEPTH));
  assign sts.sh_at_idx  = (sh_r == idx_r);
  assign sts.out_free   = !out_valid_r || out_ready;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.full)
    else $error("insert into a full table");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwrites an untaken result");

  a_changed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && res_changed_r) |=> (out_status_r == sta_pkg::ST_OK))
    else $error("table change reported with an error status");
`endif

endmodule

// ===== rtl/sorted_trigger_action_table.sv =====
// Sorted trigger/action table: maps 8-bit trigger codes to 8-bit action codes.
// Input channel (in_valid/in_ready): one get or set request per item.
// Result channel (out_valid/out_ready): exactly one result item per request,
// in request order, held in an output register until taken.
// Config channel (cfg_valid/cfg_ready): writes the five range registers by
// index; always ready; write only while no request is in flight.
// The search reads one table entry at a time from a single read port memory
// with registered read data, and entries are moved one at a time on insert or
// remove; a rejected request skips the search.
// One request is processed at a time; in_ready is high only when idle.
// A new request is accepted while the previous result still waits; its own
// result then waits in the result registers until the output register frees up,
// so a stalled receiver stalls the block after at most one further request.
// Reset (synchronous, rst_n low) empties the table and restores the default
// range registers; entry contents are not cleared and are never read unset.
module sorted_trigger_action_table #(
  parameter int TABLE_DEPTH = sta_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [sta_pkg::CODE_W-1:0]    in_trigger,
  input  logic [sta_pkg::CODE_W-1:0]    in_action,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [sta_pkg::CODE_W-1:0]    out_action_out,
  output logic                          out_changed,
  output logic [sta_pkg::COUNT_W-1:0]   out_entry_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sta_pkg::CODE_W-1:0]    cfg_data
);

  sta_pkg::ctl_cmd_t cmd;
  sta_pkg::dp_sts_t  sts;

  sta_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sta_dp #(
    .DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_trigger      (in_trigger),
    .in_action       (in_action),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_action_out  (out_action_out),
    .out_changed     (out_changed),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ===== tb/sv/tb.sv =====
// testbench for sorted_trigger_action_table: get/set requests against a sorted
// trigger/action table, checked item by item against a behavioral table model
// depends on sta_pkg (codes, status enum, range register indexes and reset values)
module tb;
  import sta_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TBL_DEPTH      = TABLE_DEPTH_DEF;
  localparam int POOL_N         = 12;
  localparam int PHASE_ITEMS    = 212;
  localparam int RAND_PHASES    = 8;
  localparam int TIMEOUT_CYCLES = 1000000;

  typedef struct packed {
    logic              op;
    logic [CODE_W-1:0] trig;
    logic [CODE_W-1:0] act;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [CODE_W-1:0]  action;
    logic               changed;
    logic [COUNT_W-1:0] count;
  } reply_t;

  typedef struct packed {
    logic [CODE_W-1:0] trig;
    logic [CODE_W-1:0] act;
  } entry_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_operation = OP_GET;
  logic [CODE_W-1:0]    in_trigger = '0;
  logic [CODE_W-1:0]    in_action = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_status;
  logic [CODE_W-1:0]    out_action_out;
  logic                 out_changed;
  logic [COUNT_W-1:0]   out_entry_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TRIG_LOW;
  logic [CODE_W-1:0]    cfg_data = '0;

  // range registers as the block should hold them
  logic [CODE_W-1:0] trig_lo       = TRIG_LOW_RST;
  logic [CODE_W-1:0] trig_known_hi = TRIG_KNOWN_RST;
  logic [CODE_W-1:0] trig_supp_hi  = TRIG_SUPP_RST;
  logic [CODE_W-1:0] act_known_hi  = ACT_KNOWN_RST;
  logic [CODE_W-1:0] act_supp_hi   = ACT_SUPP_RST;

  entry_t tbl[$];          // sorted by trigger, at most TBL_DEPTH entries
  req_t   pending_req[$];
  reply_t expected_reply[$];
  logic [CODE_W-1:0] trig_pool[POOL_N];

  req_t   next_req;
  reply_t head_reply;
  int     outstanding = 0;
  int     results_seen = 0;
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  sorted_trigger_action_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_trigger      (in_trigger),
    .in_action       (in_action),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_action_out  (out_action_out),
    .out_changed     (out_changed),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    errors++;
  endtask

  function automatic logic trig_is_known(input logic [CODE_W-1:0] t);
    return t >= trig_lo && t <= trig_known_hi;
  endfunction

  function automatic int find_trigger(input logic [CODE_W-1:0] t);
    int i;
    for (i = 0; i < tbl.size(); i++) begin
      if (tbl[i].trig == t) return i;
    end
    return -1;
  endfunction

  // applies one request to the table model and returns the reply it should give
  function automatic reply_t apply_request(input req_t r);
    reply_t y;
    entry_t e;
    int idx;
    int pos;
    int i;
    y.status  = ST_OK;
    y.action  = ACT_NONE;
    y.changed = 1'b0;
    if (r.op == OP_GET) begin
      if (trig_is_known(r.trig)) begin
        idx = find_trigger(r.trig);
        if (idx >= 0) y.action = tbl[idx].act;
      end
    end else if (!trig_is_known(r.trig) || r.act > act_known_hi) begin
      y.status = ST_INVALID;
    end else if (r.trig < trig_lo || r.trig > trig_supp_hi || r.act > act_supp_hi) begin
      y.status = ST_UNSUPPORTED;
    end else begin
      idx = find_trigger(r.trig);
      if (r.act == ACT_NONE) begin
        if (idx >= 0) begin
          tbl.delete(idx);
          y.changed = 1'b1;
        end
      end else if (idx >= 0) begin
        if (tbl[idx].act != r.act) begin
          tbl[idx].act = r.act;
          y.changed = 1'b1;
        end
      end else if (tbl.size() >= TBL_DEPTH) begin
        y.status = ST_FULL;
      end else begin
        pos = tbl.size();
        for (i = tbl.size() - 1; i >= 0; i--) begin
          if (tbl[i].trig > r.trig) pos = i;
        end
        e.trig = r.trig;
        e.act  = r.act;
        tbl.insert(pos, e);
        y.changed = 1'b1;
      end
    end
    y.count = COUNT_W'(tbl.size());
    return y;
  endfunction

  // driver: holds an item until accepted, then maybe idles before the next
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_reply.push_back(apply_request('{in_operation, in_trigger, in_action}));
    end
    if (rst_n && (!in_valid || in_ready)) begin
      if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_req.pop_front();
        in_valid     <= 1'b1;
        in_operation <= next_req.op;
        in_trigger   <= next_req.trig;
        in_action    <= next_req.act;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compares every result item with the oldest expected reply
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_reply.size() == 0) begin
        report_mismatch("result item with no request waiting");
      end else begin
        head_reply = expected_reply.pop_front();
        outstanding--;
        if (out_status !== head_reply.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, head_reply.status));
        if (out_action_out !== head_reply.action)
          report_mismatch($sformatf("action %0d, want %0d", out_action_out,
                                    head_reply.action));
        if (out_changed !== head_reply.changed)
          report_mismatch($sformatf("changed %0d, want %0d", out_changed,
                                    head_reply.changed));
        if (out_entry_count !== head_reply.count)
          report_mismatch($sformatf("entry count %0d, want %0d", out_entry_count,
                                    head_reply.count));
      end
      results_seen++;
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic add_req(input logic op, input logic [CODE_W-1:0] t,
                         input logic [CODE_W-1:0] a);
    pending_req.push_back('{op, t, a});
    outstanding++;
  endtask

  task automatic add_random_req();
    logic              op;
    logic [CODE_W-1:0] t;
    logic [CODE_W-1:0] a;
    int                sel;
    op  = ($urandom_range(1) == 1) ? OP_SET : OP_GET;
    sel = $urandom_range(99);
    if (sel < 70) begin
      t = trig_pool[$urandom_range(POOL_N - 1)];
    end else if (sel < 85) begin
      // range edges, just inside and just outside
      case ($urandom_range(5))
        0: t = trig_lo;
        1: t = trig_lo - 8'd1;
        2: t = trig_supp_hi;
        3: t = trig_supp_hi + 8'd1;
        4: t = trig_known_hi;
        default: t = trig_known_hi + 8'd1;
      endcase
    end else begin
      t = CODE_W'($urandom_range(255));
    end
    sel = $urandom_range(99);
    if (sel < 15) begin
      a = ACT_NONE;
    end else if (sel < 70) begin
      a = CODE_W'($urandom_range(act_supp_hi));
    end else if (sel < 80) begin
      case ($urandom_range(2))
        0: a = act_supp_hi + 8'd1;
        1: a = act_known_hi;
        default: a = act_known_hi + 8'd1;
      endcase
    end else begin
      a = CODE_W'($urandom_range(255));
    end
    add_req(op, t, a);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // writes all five range registers back to back, valid held high throughout
  task automatic write_ranges(input logic [CODE_W-1:0] lo, input logic [CODE_W-1:0] tk,
                              input logic [CODE_W-1:0] ts, input logic [CODE_W-1:0] ak,
                              input logic [CODE_W-1:0] as_);
    cfg_valid <= 1'b1;
    write_one(CFG_TRIG_LOW, lo);
    trig_lo = lo;
    write_one(CFG_TRIG_KNOWN, tk);
    trig_known_hi = tk;
    write_one(CFG_TRIG_SUPP, ts);
    trig_supp_hi = ts;
    write_one(CFG_ACT_KNOWN, ak);
    act_known_hi = ak;
    write_one(CFG_ACT_SUPP, as_);
    act_supp_hi = as_;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 87 : (mode == IDLE_BOTH) ? 26 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 87 : (mode == IDLE_BOTH) ? 26 : 0;
  endtask

  initial begin
    int                ph;
    int                k;
    logic [CODE_W-1:0] lo;
    logic [CODE_W-1:0] tk;
    logic [CODE_W-1:0] ts;
    logic [CODE_W-1:0] ak;
    logic [CODE_W-1:0] as_;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default ranges: triggers 0..5 known, 0..3 supported; same for actions
    add_req(OP_GET, 8'd0, 8'd0);      // empty table
    add_req(OP_GET, 8'd255, 8'd255);  // unknown trigger, action field ignored
    add_req(OP_SET, 8'd6, 8'd1);      // unknown trigger
    add_req(OP_SET, 8'd1, 8'd6);      // unknown action
    add_req(OP_SET, 8'd4, 8'd1);      // known trigger, not supported
    add_req(OP_SET, 8'd2, 8'd4);      // known action, not supported
    add_req(OP_SET, 8'd2, ACT_NONE);  // remove with no entry
    add_req(OP_SET, 8'd3, 8'd3);
    add_req(OP_SET, 8'd1, 8'd2);
    add_req(OP_SET, 8'd0, 8'd1);      // insert at the front
    add_req(OP_SET, 8'd2, 8'd1);      // insert in the middle
    add_req(OP_SET, 8'd1, 8'd2);      // same action again
    add_req(OP_SET, 8'd1, 8'd3);
    add_req(OP_GET, 8'd1, 8'd0);
    add_req(OP_SET, 8'd1, ACT_NONE);  // remove and close the gap
    add_req(OP_GET, 8'd1, 8'd0);
    wait_drained();

    // everything known and supported, fill the table to the top
    write_ranges(8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    add_req(OP_SET, 8'd255, 8'd255);
    add_req(OP_SET, 8'd128, 8'd7);
    add_req(OP_SET, 8'd200, 8'd1);
    add_req(OP_SET, 8'd50, 8'd2);
    add_req(OP_SET, 8'd100, 8'd9);
    add_req(OP_SET, 8'd7, 8'd1);      // new trigger, table full
    add_req(OP_SET, 8'd50, 8'd3);     // existing trigger in a full table
    add_req(OP_GET, 8'd255, 8'd0);
    add_req(OP_SET, 8'd0, ACT_NONE);
    wait_drained();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin lo = TRIG_LOW_RST; tk = TRIG_KNOWN_RST; ts = TRIG_SUPP_RST;
                 ak = ACT_KNOWN_RST; as_ = ACT_SUPP_RST; end
        1: begin lo = 8'd0; tk = 8'd255; ts = 8'd255; ak = 8'd255; as_ = 8'd255; end
        2: begin lo = 8'd255; tk = 8'd255; ts = 8'd255; ak = 8'd255; as_ = 8'd255; end
        3: begin lo = 8'd0; tk = 8'd0; ts = 8'd0; ak = 8'd0; as_ = 8'd0; end
        // supported reaches past known
        4: begin lo = 8'd10; tk = 8'd40; ts = 8'd60; ak = 8'd200; as_ = 8'd20; end
        // no trigger known at all
        5: begin lo = 8'd100; tk = 8'd50; ts = 8'd50; ak = 8'd9; as_ = 8'd9; end
        default: begin
          lo  = CODE_W'($urandom_range(200));
          tk  = lo + CODE_W'($urandom_range(40));
          ts  = lo + CODE_W'($urandom_range(40));
          ak  = CODE_W'($urandom_range(255));
          as_ = CODE_W'($urandom_range(ak));
        end
      endcase
      write_ranges(lo, tk, ts, ak, as_);
      set_idling(idle_mode_t'(ph % 4));
      // a small working set of triggers so that entries get hit, filled and removed
      for (k = 0; k < POOL_N; k++) begin
        trig_pool[k] = CODE_W'($urandom_range(tk, lo));
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        add_random_req();
      end
      wait_drained();
    end

    set_idling(IDLE_NONE);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d items outstanding", outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
